// ===== rtl/gradient_colormap_pixel_top_assert.svh =====
// assertion macros used by the checker file
`ifndef GRADIENT_COLORMAP_PIXEL_TOP_ASSERT_SVH
`define GRADIENT_COLORMAP_PIXEL_TOP_ASSERT_SVH

// same-cycle implication, held off while reset is low
`define GCP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, held off while reset is low
`define GCP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/gcp_pkg.sv =====
package gcp_pkg;

  localparam int LEVEL_W     = 17;
  localparam int FRAC_W      = 16;
  localparam int ARGB_W      = 32;
  localparam int CNT_W       = 3;
  localparam int NUM_ANCHORS = 7;
  localparam int MAX_SEG     = NUM_ANCHORS - 1;
  localparam int SEG_W       = 3;
  localparam int CH_W        = 8;
  localparam int NUM_CH      = 4;
  localparam int QUOT_W      = 8;
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 32;
  localparam int CFG_IDX_W   = 3;

  typedef logic [ARGB_W-1:0] argb_t;

  localparam logic [CNT_W-1:0] COUNT_RST = 3'd2;
  localparam argb_t ANCHOR_RST [NUM_ANCHORS] = '{
    32'hFF00_0000, 32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0
  };

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ANCHOR_COUNT,
    REG_ANCHOR_0,
    REG_ANCHOR_1,
    REG_ANCHOR_2,
    REG_ANCHOR_3,
    REG_ANCHOR_4,
    REG_ANCHOR_5,
    REG_ANCHOR_6
  } cfg_reg_t;

  // segment choice handed from the front to the back
  typedef struct packed {
    logic             tail;
    logic [SEG_W-1:0] seg;
  } cls_t;

endpackage

// ===== rtl/gradient_colormap_pixel_top.sv =====
// Gradient colormap: one pixel level in, one ARGB8888 color out.
// Input stream in_*: in_tdata carries the level, a fraction of 65536; levels of
// 65536 and above land on the last map entry. Output stream out_*: out_tdata is
// the color, alpha in the top byte. Config port cfg_*: register 0 is the anchor
// count, registers 1 to 7 the anchor colors; write only with nothing in flight.
// Throughput is one word per clock while the output is not stalled. From input
// accept to output valid a word passes two front stages (index, then segment
// pick), the queue, a multiply stage, a magnitude stage, eight restoring
// divide stages (one quotient bit each) and the output register.
// When out_tready is low with out_tvalid high, the back pipe and output
// register hold; the front keeps taking words until the four-entry queue is
// full, so up to 17 words can be in flight before in_tready drops. The
// segment length is picked from the anchor count out of constants fixed at
// elaboration and registered in len_r, behind the count register count_r.
// Reset empties all pipes and the queue and restores the anchor count to two,
// with black and white as the first two anchors and the rest cleared.
module gradient_colormap_pixel_top #(
  parameter int MAP_SIZE    = 255,
  parameter int MAX_ANCHORS = 7
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [gcp_pkg::IN_TDATA_W-1:0]    in_tdata,    // [16:0] level
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [gcp_pkg::OUT_TDATA_W-1:0]   out_tdata,   // [31:0] argb
  input  logic                              cfg_we,
  input  logic [gcp_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [gcp_pkg::ARGB_W-1:0]        cfg_wdata
);

  import gcp_pkg::*;

  localparam int LW      = $clog2(MAP_SIZE + 1);
  localparam int ENTRY_W = $bits(cls_t) + LW;
  localparam int Q_DEPTH = 4;
  localparam logic [CNT_W-1:0] MIN_CNT = CNT_W'(2);
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_ANCHORS);
  localparam logic [LW-1:0] LEN1 = LW'(MAP_SIZE / 1);
  localparam logic [LW-1:0] LEN2 = LW'(MAP_SIZE / 2);
  localparam logic [LW-1:0] LEN3 = LW'(MAP_SIZE / 3);
  localparam logic [LW-1:0] LEN4 = LW'(MAP_SIZE / 4);
  localparam logic [LW-1:0] LEN5 = LW'(MAP_SIZE / 5);
  localparam logic [LW-1:0] LEN6 = LW'(MAP_SIZE / 6);

  logic [CNT_W-1:0] count_r;
  argb_t            anchor_r [NUM_ANCHORS];
  logic [CNT_W-1:0] cnt_eff;
  logic [SEG_W-1:0] last_seg_r, last_seg_nxt;
  logic [LW-1:0]    len_r, len_nxt;

  logic             push_valid, push_ready;
  cls_t             push_cls;
  logic [LW-1:0]    push_offset;
  logic             pop_valid, pop_ready;
  logic [ENTRY_W-1:0] pop_data;
  cls_t             pop_cls;
  logic [LW-1:0]    pop_offset;
  argb_t            out_argb;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= COUNT_RST;
      anchor_r <= ANCHOR_RST;
    end else if (cfg_we) begin
      if (cfg_index == REG_ANCHOR_COUNT) begin
        count_r <= cfg_wdata[CNT_W-1:0];
      end else begin
        anchor_r[cfg_index - CFG_IDX_W'(REG_ANCHOR_0)] <= cfg_wdata;
      end
    end
  end

  // clamp the count, then look up the segment length
  always_comb begin
    if (count_r < MIN_CNT) begin
      cnt_eff = MIN_CNT;
    end else if (count_r > MAX_CNT) begin
      cnt_eff = MAX_CNT;
    end else begin
      cnt_eff = count_r;
    end
    last_seg_nxt = SEG_W'(cnt_eff - 1'b1);
    case (last_seg_nxt)
      3'd1:    len_nxt = LEN1;
      3'd2:    len_nxt = LEN2;
      3'd3:    len_nxt = LEN3;
      3'd4:    len_nxt = LEN4;
      3'd5:    len_nxt = LEN5;
      3'd6:    len_nxt = LEN6;
      default: len_nxt = LEN1;
    endcase
  end

  always_ff @(posedge clk) begin
    last_seg_r <= last_seg_nxt;
    len_r      <= len_nxt;
  end

  gcp_front #(
    .MAP_SIZE (MAP_SIZE)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_tvalid),
    .in_ready    (in_tready),
    .level       (in_tdata[LEVEL_W-1:0]),
    .last_seg    (last_seg_r),
    .len         (len_r),
    .push_valid  (push_valid),
    .push_ready  (push_ready),
    .push_cls    (push_cls),
    .push_offset (push_offset)
  );

  gcp_fifo #(
    .W     (ENTRY_W),
    .DEPTH (Q_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (push_valid),
    .wr_ready (push_ready),
    .wr_data  ({push_cls, push_offset}),
    .rd_valid (pop_valid),
    .rd_ready (pop_ready),
    .rd_data  (pop_data)
  );

  assign pop_cls    = cls_t'(pop_data[ENTRY_W-1:LW]);
  assign pop_offset = pop_data[LW-1:0];

  gcp_back #(
    .MAP_SIZE (MAP_SIZE)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .anchor     (anchor_r),
    .len        (len_r),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_cls    (pop_cls),
    .pop_offset (pop_offset),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_argb   (out_argb)
  );

  assign out_tdata = out_argb;

endmodule

// ===== rtl/gcp_fifo.sv =====
module gcp_fifo #(
  parameter int W     = 16,
  parameter int DEPTH = 4
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         wr_valid,
  output logic         wr_ready,
  input  logic [W-1:0] wr_data,
  output logic         rd_valid,
  input  logic         rd_ready,
  output logic [W-1:0] rd_data
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [AW-1:0] PTR_LAST = AW'(DEPTH - 1);
  localparam logic [AW:0]   CNT_FULL = (AW + 1)'(DEPTH);

  logic [W-1:0]  mem_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [AW:0]   cnt_r, cnt_nxt;
  logic          push, pop;

  assign wr_ready = (cnt_r != CNT_FULL);
  assign rd_valid = (cnt_r != '0);
  assign rd_data  = mem_r[rd_ptr_r];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

// ===== rtl/gcp_front.sv =====
module gcp_front #(
  parameter int MAP_SIZE = 255
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [gcp_pkg::LEVEL_W-1:0]        level,
  input  logic [gcp_pkg::SEG_W-1:0]          last_seg,
  input  logic [$clog2(MAP_SIZE + 1)-1:0]    len,
  output logic                               push_valid,
  input  logic                               push_ready,
  output gcp_pkg::cls_t                      push_cls,
  output logic [$clog2(MAP_SIZE + 1)-1:0]    push_offset
);

  import gcp_pkg::*;

  localparam int IW         = $clog2(MAP_SIZE);
  localparam int LW         = $clog2(MAP_SIZE + 1);
  localparam int PROD_W     = LEVEL_W + LW;
  localparam int IDX_FULL_W = PROD_W - FRAC_W;
  localparam int TW         = LW + SEG_W;
  localparam logic [PROD_W-1:0]     MAP_K        = PROD_W'(MAP_SIZE);
  localparam logic [IW-1:0]         IDX_MAX      = IW'(MAP_SIZE - 1);
  localparam logic [IDX_FULL_W-1:0] IDX_MAX_FULL = IDX_FULL_W'(MAP_SIZE - 1);

  logic              v1_r, v1_nxt;
  logic              v2_r, v2_nxt;
  logic              s2_free;
  logic [IW-1:0]     idx_r, idx_nxt;
  cls_t              cls_r, cls_nxt;
  logic [LW-1:0]     off_r, off_nxt;

  logic [PROD_W-1:0]     prod;
  logic [IDX_FULL_W-1:0] idx_full;
  logic [TW-1:0]         thr [MAX_SEG];
  logic [MAX_SEG-1:0]    above;
  logic [SEG_W-1:0]      seg;
  logic [TW-1:0]         base;
  logic [TW-1:0]         idx_ext;
  logic [TW-1:0]         off_ext;
  logic [SEG_W-1:0]      tail_sel;

  assign s2_free    = !v2_r || push_ready;
  assign in_ready   = !v1_r || s2_free;
  assign push_valid = v2_r;
  assign push_cls   = cls_r;
  assign push_offset = off_r;

  // level to map index, clamped at the top entry
  always_comb begin
    prod     = PROD_W'(level) * MAP_K;
    idx_full = prod[PROD_W-1:FRAC_W];
    idx_nxt  = (idx_full > IDX_MAX_FULL) ? IDX_MAX : idx_full[IW-1:0];
  end

  // segment boundaries are multiples of the segment length
  always_comb begin
    idx_ext  = TW'(idx_r);
    tail_sel = last_seg - 1'b1;
    seg      = '0;
    for (int k = 0; k < MAX_SEG; k++) begin
      thr[k]   = TW'(len) * TW'(k + 1);
      above[k] = (idx_ext >= thr[k]);
    end
    for (int k = 0; k < MAX_SEG; k++) begin
      if (above[k] && (SEG_W'(k + 1) < last_seg)) begin
        seg = seg + 1'b1;
      end
    end
    base    = (seg == '0) ? '0 : thr[seg - 1'b1];
    off_ext = idx_ext - base;
    // past the last whole segment: last anchor, no blend
    if (above[tail_sel]) begin
      cls_nxt.tail = 1'b1;
      cls_nxt.seg  = last_seg;
      off_nxt      = '0;
    end else begin
      cls_nxt.tail = 1'b0;
      cls_nxt.seg  = seg;
      off_nxt      = off_ext[LW-1:0];
    end
  end

  always_comb begin
    v1_nxt = in_ready ? in_valid : v1_r;
    v2_nxt = s2_free ? v1_r : v2_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= v1_nxt;
      v2_r <= v2_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      idx_r <= idx_nxt;
    end
    if (s2_free) begin
      cls_r <= cls_nxt;
      off_r <= off_nxt;
    end
  end

endmodule

// ===== rtl/gcp_back.sv =====
module gcp_back #(
  parameter int MAP_SIZE = 255
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  gcp_pkg::argb_t                  anchor [gcp_pkg::NUM_ANCHORS],
  input  logic [$clog2(MAP_SIZE + 1)-1:0] len,
  input  logic                            pop_valid,
  output logic                            pop_ready,
  input  gcp_pkg::cls_t                   pop_cls,
  input  logic [$clog2(MAP_SIZE + 1)-1:0] pop_offset,
  output logic                            out_valid,
  input  logic                            out_ready,
  output gcp_pkg::argb_t                  out_argb
);

  import gcp_pkg::*;

  localparam int LW    = $clog2(MAP_SIZE + 1);
  localparam int PW    = CH_W + LW;
  localparam int PRD_W = PW + 2;
  localparam int NSTG  = 2 + QUOT_W;
  localparam int NDIV  = QUOT_W + 1;

  logic                    en;
  logic [NSTG-1:0]         v_r, v_nxt;
  logic                    out_valid_r, out_valid_nxt;
  argb_t                   out_argb_r, out_argb_nxt;

  // per-stage carried payload
  logic [NSTG-1:0]         tail_r;
  logic [CH_W-1:0]         base_r [NSTG][NUM_CH];
  logic signed [PRD_W-1:0] prd_r [NUM_CH];
  logic [PW-1:0]           rem_r [NDIV][NUM_CH];
  logic [QUOT_W-1:0]       quo_r [NDIV][NUM_CH];
  logic                    neg_r [NDIV][NUM_CH];

  logic signed [PRD_W-1:0] prd_nxt [NUM_CH];
  logic [CH_W-1:0]         base_nxt [NUM_CH];
  logic [PW-1:0]           rem_nxt [NDIV][NUM_CH];
  logic [QUOT_W-1:0]       quo_nxt [NDIV][NUM_CH];
  logic                    neg_nxt [NUM_CH];

  argb_t                   c0, c1;
  logic [SEG_W-1:0]        seg_up;
  logic signed [CH_W:0]    diff;
  logic signed [PRD_W-1:0] mag;
  logic [PW-1:0]           dvs;
  logic [CH_W-1:0]         step;

  assign en        = !out_valid_r || out_ready;
  assign pop_ready = en;
  assign out_valid = out_valid_r;
  assign out_argb  = out_argb_r;

  // anchor pair and signed delta times offset
  always_comb begin
    seg_up = pop_cls.seg + 1'b1;
    c0 = (pop_cls.seg < SEG_W'(NUM_ANCHORS)) ? anchor[pop_cls.seg] : '0;
    c1 = (seg_up < SEG_W'(NUM_ANCHORS)) ? anchor[seg_up] : '0;
    for (int c = 0; c < NUM_CH; c++) begin
      base_nxt[c] = c0[c*CH_W +: CH_W];
      diff = $signed({1'b0, c1[c*CH_W +: CH_W]}) - $signed({1'b0, c0[c*CH_W +: CH_W]});
      prd_nxt[c] = PRD_W'(diff) * $signed(PRD_W'(pop_offset));
    end
  end

  // magnitude, then one quotient bit per stage, msb first
  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      neg_nxt[c]    = prd_r[c][PRD_W-1];
      mag           = neg_nxt[c] ? -prd_r[c] : prd_r[c];
      rem_nxt[0][c] = mag[PW-1:0];
      quo_nxt[0][c] = '0;
    end
    for (int j = 1; j < NDIV; j++) begin
      for (int c = 0; c < NUM_CH; c++) begin
        dvs           = PW'(len) << (QUOT_W - j);
        rem_nxt[j][c] = rem_r[j-1][c];
        quo_nxt[j][c] = quo_r[j-1][c];
        if (rem_r[j-1][c] >= dvs) begin
          rem_nxt[j][c] = rem_r[j-1][c] - dvs;
          quo_nxt[j][c][QUOT_W - j] = 1'b1;
        end
      end
    end
  end

  // round toward zero: negate quotient if product < 0; tail adds 0; 8-bit wrap
  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      step = neg_r[NDIV-1][c] ? -quo_r[NDIV-1][c] : quo_r[NDIV-1][c];
      if (tail_r[NSTG-1]) begin
        step = '0;
      end
      out_argb_nxt[c*CH_W +: CH_W] = base_r[NSTG-1][c] + step;
    end
  end

  always_comb begin
    v_nxt         = v_r;
    out_valid_nxt = out_valid_r;
    if (en) begin
      v_nxt         = {v_r[NSTG-2:0], pop_valid};
      out_valid_nxt = v_r[NSTG-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      v_r         <= v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tail_r    <= {tail_r[NSTG-2:0], pop_cls.tail};
      base_r[0] <= base_nxt;
      for (int s = 1; s < NSTG; s++) begin
        base_r[s] <= base_r[s-1];
      end
      prd_r <= prd_nxt;
      for (int j = 0; j < NDIV; j++) begin
        rem_r[j] <= rem_nxt[j];
        quo_r[j] <= quo_nxt[j];
      end
      neg_r[0] <= neg_nxt;
      for (int j = 1; j < NDIV; j++) begin
        neg_r[j] <= neg_r[j-1];
      end
      out_argb_r <= out_argb_nxt;
    end
  end

endmodule

// ===== rtl/gcp_checker.sv =====
`include "gradient_colormap_pixel_top_assert.svh"

module gcp_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [gcp_pkg::OUT_TDATA_W-1:0] out_tdata
);

  import gcp_pkg::*;

  localparam int MAX_INFLIGHT = 17;
  localparam int OW = $clog2(MAX_INFLIGHT + 1);
  localparam logic [OW-1:0] INFLIGHT_LIM = OW'(MAX_INFLIGHT);

  logic          in_acc, out_acc;
  logic [OW-1:0] inflight_r, inflight_nxt;

  assign in_acc  = in_tvalid && in_tready;
  assign out_acc = out_tvalid && out_tready;

  always_comb begin
    inflight_nxt = inflight_r;
    if (in_acc && !out_acc) begin
      inflight_nxt = inflight_r + 1'b1;
    end else if (out_acc && !in_acc) begin
      inflight_nxt = inflight_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inflight_r <= '0;
    end else begin
      inflight_r <= inflight_nxt;
    end
  end

  `GCP_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "stalled output word changed")
  `GCP_ASSERT_NOW(a_no_phantom, out_tvalid, inflight_r != '0, "output word with no input word in flight")
  `GCP_ASSERT_NOW(a_inflight_cap, 1'b1, inflight_r <= INFLIGHT_LIM, "more words in flight than the pipe holds")
  `GCP_ASSERT_NOW(a_ready_when_empty, inflight_r == '0, in_tready, "input not ready with nothing in flight")
  `GCP_ASSERT_NOW(a_reset_empty, $past(!rst_n), !out_tvalid, "output valid right after reset")

endmodule

bind gradient_colormap_pixel_top gcp_checker u_gcp_checker (.*);

// ===== verif/gradient_colormap_pixel_top_tb.sv =====
module gradient_colormap_pixel_top_tb;
  import gcp_pkg::*;

  localparam int MAP_SIZE     = 255;
  localparam int MAX_ANCHORS  = 7;
  localparam int PHASE_WORDS  = 150;
  localparam int NUM_PHASES   = 12;
  localparam int HOLD_CYCLES  = 80;
  localparam int IDLE_LIMIT   = 2000;
  localparam int SETTLE_CYCLES = 20;

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;     // [16:0] level
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;    // [31:0] argb
  logic                   cfg_we;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [ARGB_W-1:0]      cfg_wdata;

  bit no_idle;
  bit hold_req;
  int settings_used;
  int idle_cycles;

  gradient_colormap_pixel_top #(
    .MAP_SIZE(MAP_SIZE),
    .MAX_ANCHORS(MAX_ANCHORS)
  ) u_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  class color_scoreboard;
    logic [CNT_W-1:0]  count_reg;
    logic [ARGB_W-1:0] anchors [NUM_ANCHORS];
    logic [ARGB_W-1:0] color_queue [$];
    logic [16:0]       level_queue [$];
    int                errors;
    int                compared;

    function new();
      count_reg = COUNT_RST;
      anchors   = ANCHOR_RST;
      errors    = 0;
      compared  = 0;
    endfunction

    function void write_reg(cfg_reg_t idx, logic [ARGB_W-1:0] val);
      if (idx == REG_ANCHOR_COUNT) begin
        count_reg = val[CNT_W-1:0];
      end else begin
        anchors[int'(idx) - int'(REG_ANCHOR_0)] = val;
      end
    endfunction

    function logic [ARGB_W-1:0] map_level(logic [16:0] lvl);
      int unsigned cnt, idx, len, seg, offs;
      int b, e, step, ch;
      logic [ARGB_W-1:0] c0, c1, color;
      cnt = count_reg;
      if (cnt < 2) cnt = 2;
      if (cnt > MAX_ANCHORS) cnt = MAX_ANCHORS;
      idx = ({15'b0, lvl} * MAP_SIZE) >> 16;
      if (idx > MAP_SIZE - 1) idx = MAP_SIZE - 1;
      len = MAP_SIZE / (cnt - 1);
      if (len == 0) return anchors[cnt-1];
      seg = idx / len;
      // tail past the last whole segment takes the last anchor
      if (seg >= cnt - 1) return anchors[cnt-1];
      offs = idx - seg * len;
      c0 = anchors[seg];
      c1 = anchors[seg+1];
      for (ch = 0; ch < NUM_CH; ch++) begin
        b = {24'b0, c0[ch*CH_W +: CH_W]};
        e = {24'b0, c1[ch*CH_W +: CH_W]};
        // signed division truncates toward zero
        step = ((e - b) * int'(offs)) / int'(len);
        color[ch*CH_W +: CH_W] = 8'(b + step);
      end
      return color;
    endfunction

    function void note_level(logic [16:0] lvl);
      level_queue.push_back(lvl);
      color_queue.push_back(map_level(lvl));
    endfunction

    task report(string what);
      $display("mismatch: %s", what);
      errors++;
    endtask

    task check_color(logic [ARGB_W-1:0] got);
      logic [ARGB_W-1:0] want;
      logic [16:0] lvl;
      if (color_queue.size() == 0) begin
        report($sformatf("color %08h arrived with no pixel pending", got));
      end else begin
        want = color_queue.pop_front();
        lvl  = level_queue.pop_front();
        compared++;
        if (got !== want)
          report($sformatf("level %05h: argb %08h, want %08h", lvl, got, want));
      end
    endtask

    function int pending();
      return color_queue.size();
    endfunction
  endclass

  color_scoreboard sb = new();

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic int stall_len();
    if ($urandom_range(0, 99) < 80) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic int sender_gap();
    if (no_idle || $urandom_range(0, 99) < 65) return 0;
    return stall_len();
  endfunction

  function automatic logic [16:0] rand_level();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 17'($urandom_range(0, 65536));
    if (r < 80) begin
      case ($urandom_range(0, 3))
        0: return 17'd0;
        1: return 17'd65279;
        2: return 17'd65535;
        default: return 17'd65536;
      endcase
    end
    return 17'($urandom);
  endfunction

  function automatic logic [ARGB_W-1:0] rand_anchor();
    if ($urandom_range(0, 3) == 0) begin
      case ($urandom_range(0, 3))
        0: return 32'h0000_0000;
        1: return 32'hFFFF_FFFF;
        2: return 32'h00FF_00FF;
        default: return 32'hFF00_FF00;
      endcase
    end
    return $urandom;
  endfunction

  // called at a falling edge; returns at a falling edge
  task automatic send_level(logic [16:0] lvl);
    int gap;
    gap = sender_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {7'b0, lvl};
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  task automatic wait_drain();
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  // block must be idle; writes all registers back to back
  task automatic apply_settings(logic [CNT_W-1:0] count, logic [ARGB_W-1:0] colors [NUM_ANCHORS]);
    int i;
    cfg_we    <= 1'b1;
    cfg_index <= REG_ANCHOR_COUNT;
    cfg_wdata <= {29'b0, count};
    sb.write_reg(REG_ANCHOR_COUNT, {29'b0, count});
    @(negedge clk);
    for (i = 0; i < NUM_ANCHORS; i++) begin
      cfg_index <= CFG_IDX_W'(int'(REG_ANCHOR_0) + i);
      cfg_wdata <= colors[i];
      sb.write_reg(cfg_reg_t'(int'(REG_ANCHOR_0) + i), colors[i]);
      @(negedge clk);
    end
    cfg_we <= 1'b0;
    settings_used++;
    // segment length is registered behind the count register
    repeat (2) @(negedge clk);
  endtask

  // receiver side
  initial begin
    out_tready = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      if (hold_req) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end else if (!no_idle && $urandom_range(0, 9) == 0) begin
        out_tready <= 1'b0;
        repeat (stall_len()) @(negedge clk);
      end else begin
        out_tready <= 1'b1;
        @(negedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) sb.note_level(in_tdata[16:0]);
      if (out_tvalid && out_tready) sb.check_color(out_tdata);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles + 1 >= IDLE_LIMIT) begin
        $display("timeout: no word moved for %0d cycles", IDLE_LIMIT);
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  initial begin
    logic [16:0] edge_levels [11];
    logic [ARGB_W-1:0] colors [NUM_ANCHORS];
    int p, n, i;
    edge_levels = '{17'd0, 17'd1, 17'd257, 17'd32768, 17'd65279, 17'd65535,
                    17'd65536, 17'd65537, 17'h1FFFF, 17'h15555, 17'h0AAAA};
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    cfg_we    = 1'b0;
    cfg_index = REG_ANCHOR_COUNT;
    cfg_wdata = '0;
    no_idle   = 1'b0;
    hold_req  = 1'b0;
    settings_used = 1;
    idle_cycles = 0;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset gradient, black to white, over the level extremes
    for (i = 0; i < 11; i++) send_level(edge_levels[i]);
    wait_drain();

    // all seven anchors, channels rising and falling at the extremes
    colors = '{32'h00FF_00FF, 32'hFF00_FF00, 32'h0000_0000, 32'hFFFF_FFFF,
               32'h8080_8080, 32'h7F7F_7F7F, 32'h1234_5678};
    apply_settings(3'd7, colors);
    for (i = 0; i < 11; i++) send_level(edge_levels[i]);
    wait_drain();

    for (p = 0; p < NUM_PHASES; p++) begin
      for (i = 0; i < NUM_ANCHORS; i++) colors[i] = rand_anchor();
      // first phases sweep every count, including the clamped ones
      apply_settings((p < 8) ? CNT_W'(p) : CNT_W'($urandom_range(0, 7)), colors);
      no_idle = (p % 5 == 4);
      n = 0;
      if (p == 3) begin
        // receiver holds off while words keep coming, filling the queue
        hold_req = 1'b1;
        for (i = 0; i < 40; i++) begin
          in_tvalid <= 1'b1;
          in_tdata  <= {7'b0, rand_level()};
          do @(posedge clk); while (!in_tready);
          @(negedge clk);
        end
        n = 40;
      end
      for (i = n; i < PHASE_WORDS; i++) send_level(rand_level());
      wait_drain();
    end

    no_idle = 1'b0;
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    $display("run covered %0d pixel words under %0d register settings",
             sb.compared, settings_used);
    $display("level extremes, clamped anchor counts and a long output stall included");
    if (sb.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/gcp_pkg.sv
rtl/gcp_fifo.sv
rtl/gcp_front.sv
rtl/gcp_back.sv
rtl/gradient_colormap_pixel_top.sv
rtl/gcp_checker.sv
verif/gradient_colormap_pixel_top_tb.sv
